@@ rtl/aap_pkg.sv @@
// Shared types, constants and helpers for the adaptive average pooling core.
// Used by every module of the block; depends on nothing.
package aap_pkg;

  localparam int unsigned MaxWidth   = 1024;
  localparam int unsigned MaxHeight  = 1024;
  localparam int unsigned SampleBits = 16;
  localparam int unsigned SizeBits   = 11;
  localparam int unsigned PosBits    = 10;
  localparam int unsigned HSumBits   = 26;
  localparam int unsigned AccBits    = 36;
  localparam int unsigned ProdBits   = 21;
  localparam int unsigned AreaBits   = 21;
  localparam int unsigned NumBits    = 38;
  localparam int unsigned DenBits    = 22;
  localparam int unsigned QuoBits    = 17;
  localparam int unsigned CntBits    = 6;
  localparam int unsigned FifoDepth  = 4;
  localparam int unsigned FifoPtrBits = 2;
  localparam int unsigned CfgIdxBits = 8;

  typedef enum logic [CfgIdxBits-1:0] {
    RegInHeight  = 8'd0,
    RegInWidth   = 8'd1,
    RegOutHeight = 8'd2,
    RegOutWidth  = 8'd3
  } cfg_reg_e;

  // clamped plane geometry
  typedef struct packed {
    logic [SizeBits-1:0] h;
    logic [SizeBits-1:0] w;
    logic [SizeBits-1:0] oh;
    logic [SizeBits-1:0] ow;
  } size_t;

  // one closed column window of one input row
  typedef struct packed {
    logic signed [HSumBits-1:0] h;
    logic [PosBits-1:0]         c;
    logic [PosBits-1:0]         r;
    logic                       sel;
    logic                       first;
    logic                       nxt_en;
    logic                       nxt_first;
    logic                       emit;
    logic                       done;
    logic [SizeBits-1:0]        hgt;
    logic [SizeBits-1:0]        wid;
  } col_event_t;

  function automatic logic [SizeBits-1:0] clamp_size(input logic [SizeBits-1:0] v,
                                                     input logic [SizeBits-1:0] hi);
    logic [SizeBits-1:0] res;
    if (v == '0) begin
      res = SizeBits'(1);
    end else if (v > hi) begin
      res = hi;
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

@@ rtl/adaptive_avg_pool_2d_core.sv @@
// Adaptive 2-D average pooling core: configuration registers and the
// front/queue/back assembly. Uses aap_pkg, aap_front, aap_fifo, aap_back.
//
// Samples (signed Q8.8) stream in row-major order, planes back to back. The
// front takes one sample per cycle while not stalled (full queue, restart);
// each time a column window closes it queues a request for the back end (four
// entries deep). The back end takes one request at a time: one that only
// updates the column accumulators passes through accumulate; one that closes
// a full window goes through accumulate, area, 38-step rounding divider and
// result register. Any write to a size register restarts the plane, and in
// the cycle after the write no sample is taken.
module adaptive_avg_pool_2d_core import aap_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CfgIdxBits-1:0] cfg_index_i,
  input  logic [SizeBits-1:0]   cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [SampleBits-1:0] sample_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [SampleBits-1:0] average_o,
  output logic [PosBits-1:0]    out_row_o,
  output logic [PosBits-1:0]    out_col_o,
  output logic                  plane_done_o
);

  logic [SizeBits-1:0] in_height_q, in_width_q, out_height_q, out_width_q;
  logic                cfg_wr, restart;
  size_t               size;
  logic                push, pop, full, empty;
  col_event_t          ev_in, ev_out;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  always_comb begin
    size.h  = clamp_size(in_height_q, SizeBits'(MaxHeight));
    size.w  = clamp_size(in_width_q, SizeBits'(MaxWidth));
    size.oh = clamp_size(out_height_q, size.h);
    size.ow = clamp_size(out_width_q, size.w);
  end

  always_comb begin
    unique case (cfg_index_i)
      RegInHeight, RegInWidth, RegOutHeight, RegOutWidth: restart = cfg_wr;
      default: restart = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_height_q  <= SizeBits'(1);
      in_width_q   <= SizeBits'(1);
      out_height_q <= SizeBits'(1);
      out_width_q  <= SizeBits'(1);
    end else if (cfg_wr) begin
      case (cfg_index_i)
        RegInHeight:  in_height_q  <= cfg_data_i;
        RegInWidth:   in_width_q   <= cfg_data_i;
        RegOutHeight: out_height_q <= cfg_data_i;
        RegOutWidth:  out_width_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  aap_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .size_i     (size),
    .restart_i  (restart),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sample_i   (sample_i),
    .push_o     (push),
    .event_o    (ev_in),
    .full_i     (full)
  );

  aap_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (ev_in),
    .pop_i   (pop),
    .data_o  (ev_out),
    .full_o  (full),
    .empty_o (empty)
  );

  aap_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .event_i      (ev_out),
    .empty_i      (empty),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .average_o    (average_o),
    .out_row_o    (out_row_o),
    .out_col_o    (out_col_o),
    .plane_done_o (plane_done_o)
  );

endmodule

@@ rtl/aap_fifo.sv @@
// Short request queue between the front sequencer and the accumulation back end.
// Uses col_event_t from aap_pkg.
module aap_fifo import aap_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  col_event_t data_i,
  input  logic       pop_i,
  output col_event_t data_o,
  output logic       full_o,
  output logic       empty_o
);

  col_event_t              mem_q [FifoDepth];
  logic [FifoPtrBits-1:0]  wr_ptr_q, wr_ptr_d;
  logic [FifoPtrBits-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FifoPtrBits:0]    count_q, count_d;

  assign full_o  = (count_q == (FifoPtrBits+1)'(FifoDepth));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ rtl/aap_front.sv @@
// Front sequencer: tracks the input position and window bounds, keeps the row
// sums and issues one request per closed column window. Uses aap_pkg.
module aap_front import aap_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  size_t                 size_i,
  input  logic                  restart_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [SampleBits-1:0] sample_i,
  output logic                  push_o,
  output col_event_t            event_o,
  input  logic                  full_i
);

  logic [PosBits-1:0]         i_q, i_d, j_q, j_d, r_q, r_d, c_q, c_d;
  logic [PosBits-1:0]         rs_q, rs_d, cs_q, cs_d;
  logic [ProdBits-1:0]        a_q, a_d, b_q, b_d, ia_q, ia_d, rb_q, rb_d;
  logic signed [HSumBits-1:0] hc_q, hc_d, hn_q, hn_d;
  logic                       sel_q, sel_d, restart_q, restart_d;

  logic                       in_acc;
  logic signed [HSumBits-1:0] sx, hc_new, hn_new;
  logic [ProdBits-1:0]        a_plus, i_plus;
  logic                       col_end, ns_ge, ns_eq, row_end, nr_ge, nr_eq;
  logic                       j_last, i_last, r_last, c_last;

  assign in_stall_o = restart_q || full_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign sx     = {{(HSumBits-SampleBits){sample_i[SampleBits-1]}}, sample_i};
  assign a_plus = a_q + ProdBits'(size_i.ow);
  assign i_plus = ia_q + ProdBits'(size_i.oh);

  // column window c ends at j when (c+1)*W <= (j+1)*OW
  assign col_end = (b_q <= a_plus);
  assign ns_ge   = (b_q < a_plus);
  assign ns_eq   = ns_ge && (a_q <= b_q);
  assign row_end = (rb_q <= i_plus);
  assign nr_ge   = (rb_q < i_plus);
  assign nr_eq   = nr_ge && (ia_q <= rb_q);

  assign j_last = (SizeBits'(j_q) + SizeBits'(1) >= size_i.w);
  assign i_last = (SizeBits'(i_q) + SizeBits'(1) >= size_i.h);
  assign r_last = (SizeBits'(r_q) + SizeBits'(1) == size_i.oh);
  assign c_last = (SizeBits'(c_q) + SizeBits'(1) == size_i.ow);

  assign hc_new = (j_q == cs_q) ? sx : hc_q + sx;
  assign hn_new = ns_ge ? (ns_eq ? sx : hn_q + sx) : hn_q;

  assign push_o = in_acc && col_end;

  always_comb begin
    event_o.h         = hc_new;
    event_o.c         = c_q;
    event_o.r         = r_q;
    event_o.sel       = sel_q;
    event_o.first     = (i_q == rs_q);
    event_o.nxt_en    = nr_ge;
    event_o.nxt_first = nr_eq;
    event_o.emit      = row_end;
    event_o.done      = row_end && r_last && c_last;
    event_o.hgt       = SizeBits'(i_q - rs_q) + SizeBits'(1);
    event_o.wid       = SizeBits'(j_q - cs_q) + SizeBits'(1);
  end

  always_comb begin
    i_d = i_q; j_d = j_q; r_d = r_q; c_d = c_q;
    rs_d = rs_q; cs_d = cs_q;
    a_d = a_q; b_d = b_q; ia_d = ia_q; rb_d = rb_q;
    hc_d = hc_q; hn_d = hn_q; sel_d = sel_q;
    restart_d = restart_i;
    if (restart_q) begin
      i_d = '0; j_d = '0; r_d = '0; c_d = '0;
      rs_d = '0; cs_d = '0;
      a_d = '0; ia_d = '0;
      b_d = ProdBits'(size_i.w);
      rb_d = ProdBits'(size_i.h);
      hc_d = '0; hn_d = '0; sel_d = 1'b0;
    end else if (in_acc) begin
      hc_d = hc_new;
      hn_d = hn_new;
      if (col_end) begin
        hc_d = hn_new;
        hn_d = '0;
        c_d  = c_q + 1'b1;
        b_d  = b_q + ProdBits'(size_i.w);
        cs_d = ns_ge ? j_q : j_q + 1'b1;
      end
      if (j_last) begin
        // wrap to the next input row
        j_d = '0; c_d = '0; cs_d = '0;
        a_d = '0;
        b_d = ProdBits'(size_i.w);
        hc_d = '0; hn_d = '0;
        i_d  = i_q + 1'b1;
        ia_d = i_plus;
        if (row_end) begin
          sel_d = ~sel_q;
          r_d   = r_q + 1'b1;
          rb_d  = rb_q + ProdBits'(size_i.h);
          rs_d  = nr_ge ? i_q : i_q + 1'b1;
        end
        if (i_last || (row_end && r_last)) begin
          i_d = '0; r_d = '0; rs_d = '0; ia_d = '0;
          rb_d = ProdBits'(size_i.h);
        end
      end else begin
        j_d = j_q + 1'b1;
        a_d = a_plus;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q <= '0; j_q <= '0; r_q <= '0; c_q <= '0;
      rs_q <= '0; cs_q <= '0;
      a_q <= '0; b_q <= '0; ia_q <= '0; rb_q <= '0;
      hc_q <= '0; hn_q <= '0;
      sel_q <= 1'b0;
      restart_q <= 1'b1;
    end else begin
      i_q <= i_d; j_q <= j_d; r_q <= r_d; c_q <= c_d;
      rs_q <= rs_d; cs_q <= cs_d;
      a_q <= a_d; b_q <= b_d; ia_q <= ia_d; rb_q <= rb_d;
      hc_q <= hc_d; hn_q <= hn_d;
      sel_q <= sel_d;
      restart_q <= restart_d;
    end
  end

endmodule

@@ rtl/aap_back.sv @@
// Back end: per-column accumulator banks (ping-pong current/next output row),
// window area, rounding divider and the result register. Uses aap_pkg.
module aap_back import aap_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  col_event_t            event_i,
  input  logic                  empty_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [SampleBits-1:0] average_o,
  output logic [PosBits-1:0]    out_row_o,
  output logic [PosBits-1:0]    out_col_o,
  output logic                  plane_done_o
);

  typedef enum logic [2:0] {StIdle, StAcc, StPrep, StDiv, StOut} state_e;

  state_e                    state_q;
  col_event_t                ev_q;
  logic [AccBits-1:0]        bank0_mem [MaxWidth];
  logic [AccBits-1:0]        bank1_mem [MaxWidth];
  logic [AccBits-1:0]        rd0_q, rd1_q;
  logic signed [AccBits-1:0] sum_q;
  logic [AreaBits-1:0]       area_q;
  logic [NumBits-1:0]        num_q;
  logic [DenBits-1:0]        den_q, rem_q;
  logic [QuoBits-1:0]        quo_q;
  logic [CntBits-1:0]        cnt_q;
  logic                      neg_q;

  logic signed [AccBits-1:0] hx, cur_rd, nxt_rd, cur_sum, nxt_sum;
  logic                      acc_st, wr0_en, wr1_en;
  logic [AccBits-1:0]        wr0_data, wr1_data;
  logic [NumBits-1:0]        sum_ext, sum2, area_ext;
  logic [DenBits:0]          rem_sh;
  logic                      ge;
  logic [SampleBits-1:0]     avg;
  logic                      out_free;

  assign pop_o  = (state_q == StIdle) && !empty_i;
  assign acc_st = (state_q == StAcc);

  assign hx      = {{(AccBits-HSumBits){ev_q.h[HSumBits-1]}}, ev_q.h};
  assign cur_rd  = ev_q.sel ? rd1_q : rd0_q;
  assign nxt_rd  = ev_q.sel ? rd0_q : rd1_q;
  assign cur_sum = ev_q.first ? hx : cur_rd + hx;
  assign nxt_sum = ev_q.nxt_first ? hx : nxt_rd + hx;

  assign wr0_en   = acc_st && (!ev_q.sel || ev_q.nxt_en);
  assign wr0_data = ev_q.sel ? nxt_sum : cur_sum;
  assign wr1_en   = acc_st && (ev_q.sel || ev_q.nxt_en);
  assign wr1_data = ev_q.sel ? cur_sum : nxt_sum;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rd0_q <= bank0_mem[event_i.c];
    end
    if (wr0_en) begin
      bank0_mem[ev_q.c] <= wr0_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rd1_q <= bank1_mem[event_i.c];
    end
    if (wr1_en) begin
      bank1_mem[ev_q.c] <= wr1_data;
    end
  end

  // round half away from zero: q = (2|s| + a) / (2a), sign applied after
  assign sum_ext  = {{(NumBits-AccBits){sum_q[AccBits-1]}}, sum_q};
  assign sum2     = {sum_ext[NumBits-2:0], 1'b0};
  assign area_ext = NumBits'(area_q);
  assign rem_sh   = {rem_q, num_q[NumBits-1]};
  assign ge       = (rem_sh >= {1'b0, den_q});
  assign avg      = neg_q ? SampleBits'(~quo_q[SampleBits-1:0] + 1'b1)
                          : quo_q[SampleBits-1:0];
  assign out_free = !out_valid_o || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      out_valid_o  <= 1'b0;
      ev_q         <= '0;
      sum_q        <= '0;
      area_q       <= '0;
      num_q        <= '0;
      den_q        <= '0;
      rem_q        <= '0;
      quo_q        <= '0;
      cnt_q        <= '0;
      neg_q        <= 1'b0;
      average_o    <= '0;
      out_row_o    <= '0;
      out_col_o    <= '0;
      plane_done_o <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        out_valid_o <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (!empty_i) begin
            ev_q    <= event_i;
            state_q <= StAcc;
          end
        end
        StAcc: begin
          sum_q   <= cur_sum;
          area_q  <= AreaBits'(ev_q.hgt) * AreaBits'(ev_q.wid);
          state_q <= ev_q.emit ? StPrep : StIdle;
        end
        StPrep: begin
          neg_q   <= sum_q[AccBits-1];
          num_q   <= sum_q[AccBits-1] ? area_ext - sum2 : sum2 + area_ext;
          den_q   <= {area_q, 1'b0};
          rem_q   <= '0;
          quo_q   <= '0;
          cnt_q   <= CntBits'(NumBits - 1);
          state_q <= StDiv;
        end
        StDiv: begin
          rem_q <= ge ? DenBits'(rem_sh - {1'b0, den_q}) : rem_sh[DenBits-1:0];
          num_q <= {num_q[NumBits-2:0], 1'b0};
          quo_q <= {quo_q[QuoBits-2:0], ge};
          if (cnt_q == '0) begin
            state_q <= StOut;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        StOut: begin
          if (out_free) begin
            out_valid_o  <= 1'b1;
            average_o    <= avg;
            out_row_o    <= ev_q.r;
            out_col_o    <= ev_q.c;
            plane_done_o <= ev_q.done;
            state_q      <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

@@ rtl/aap_checker.sv @@
// Port-level checks for adaptive_avg_pool_2d_core, bound to the top level.
// Uses aap_pkg for widths and register codes.
module aap_checker import aap_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  cfg_valid_i,
  input logic                  cfg_ready_o,
  input logic [CfgIdxBits-1:0] cfg_index_i,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [SampleBits-1:0] average_o,
  input logic [PosBits-1:0]    out_row_o,
  input logic [PosBits-1:0]    out_col_o,
  input logic                  plane_done_o
);

  logic               seen_q, last_done_q;
  logic [PosBits-1:0] last_row_q, last_col_q;
  logic               out_acc, cfg_restart;

  assign out_acc     = out_valid_o && !out_stall_i;
  assign cfg_restart = cfg_valid_i && cfg_ready_o && (cfg_index_i <= RegOutWidth);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= 1'b0;
      last_done_q <= 1'b0;
      last_row_q  <= '0;
      last_col_q  <= '0;
    end else if (cfg_restart) begin
      seen_q <= 1'b0;
    end else if (out_acc) begin
      seen_q      <= 1'b1;
      last_done_q <= plane_done_o;
      last_row_q  <= out_row_o;
      last_col_q  <= out_col_o;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(average_o) &&
      $stable(out_row_o) && $stable(out_col_o) && $stable(plane_done_o))
    else $error("stalled result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_restart |=> in_stall_o)
    else $error("no restart cycle after size write");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && seen_q && !last_done_q |->
      (out_row_o > last_row_q) || (out_row_o == last_row_q && out_col_o > last_col_q))
    else $error("results out of raster order");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && seen_q && last_done_q |-> out_row_o == '0 && out_col_o == '0)
    else $error("new plane does not start at cell zero");

endmodule

bind adaptive_avg_pool_2d_core aap_checker u_aap_checker (.*);
